// File: hw/rtl/mpct_pkg.sv
`default_nettype none

package mpct_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [BYTE_W-1:0] SYNC_BIT      = 8'h08;
  localparam logic [BYTE_W-1:0] OVERFLOW_BITS = 8'hC0;
  localparam logic [BYTE_W-1:0] LEFT_BIT      = 8'h01;
  localparam logic [BYTE_W-1:0] RIGHT_BIT     = 8'h02;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [COORD_BITS-1:0] X_RESET = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] Y_RESET = COORD_BITS'(240);

endpackage

`default_nettype wire

// File: hw/rtl/mpct_motion.sv
`default_nettype none

module mpct_motion (
  input  wire logic [mpct_pkg::COORD_BITS-1:0] cursor_x_i,
  input  wire logic [mpct_pkg::COORD_BITS-1:0] cursor_y_i,
  input  wire logic [mpct_pkg::BYTE_W-1:0]     dx_i,
  input  wire logic [mpct_pkg::BYTE_W-1:0]     dy_i,
  input  wire logic [mpct_pkg::SIZE_W-1:0]     width_i,
  input  wire logic [mpct_pkg::SIZE_W-1:0]     height_i,
  output logic      [mpct_pkg::COORD_BITS-1:0] new_x_o,
  output logic      [mpct_pkg::COORD_BITS-1:0] new_y_o
);
  import mpct_pkg::*;

  localparam int unsigned LIM_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
  localparam int unsigned NX_W  = COORD_BITS + 2;
  localparam int unsigned CMP_W = LIM_W + 2;
  localparam logic [LIM_W-1:0] COORD_MAX = LIM_W'((1 << COORD_BITS) - 1);

  // size minus one, saturated at the coordinate range
  function automatic logic [COORD_BITS-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] raw;
    logic [LIM_W-1:0]  ext;
    raw = (size == '0) ? '0 : size - SIZE_W'(1);
    ext = LIM_W'(raw);
    if (ext > COORD_MAX) begin
      ext = COORD_MAX;
    end
    return ext[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [NX_W-1:0] v,
                                                  input logic [COORD_BITS-1:0] lim);
    logic [COORD_BITS-1:0] res;
    if (v[NX_W-1]) begin
      res = '0;
    end else if (CMP_W'($unsigned(v)) > CMP_W'(lim)) begin
      res = lim;
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  logic signed [NX_W-1:0] nx;
  logic signed [NX_W-1:0] ny;

  assign nx = $signed({2'b00, cursor_x_i}) + NX_W'($signed(dx_i));
  assign ny = $signed({2'b00, cursor_y_i}) - NX_W'($signed(dy_i));

  assign new_x_o = clamp(nx, limit_of(width_i));
  assign new_y_o = clamp(ny, limit_of(height_i));

endmodule

`default_nettype wire

// File: hw/rtl/mouse_packet_cursor_tracker.sv
`default_nettype none

// channel   direction  handshake                 payload
// data      in         data_valid_i/data_ready_o  data_byte_i
// result    out        out_valid_o/out_ready_i    changed, pos_x/y, buttons, motion_dropped
// config    in         cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// one word per cycle while data_ready_o is high; the edge that takes a packet's third byte loads the result register
// the result register frees on the cycle it is taken, so bytes keep flowing under it
// data_ready_o drops only while a result waits and out_ready_i is low
// reset: disabled, 640x480 screen, cursor at 320,240, buttons up, byte count zero

module mouse_packet_cursor_tracker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mpct_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mpct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             data_valid_i,
  output logic                                  data_ready_o,
  input  wire logic [mpct_pkg::BYTE_W-1:0]      data_byte_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  changed_o,
  output logic      [mpct_pkg::COORD_BITS-1:0]  pos_x_o,
  output logic      [mpct_pkg::COORD_BITS-1:0]  pos_y_o,
  output logic                                  left_button_o,
  output logic                                  right_button_o,
  output logic                                  motion_dropped_o
);
  import mpct_pkg::*;

  typedef enum logic [1:0] {
    IDX_HEADER,
    IDX_DX,
    IDX_DY
  } byte_idx_e;

  byte_idx_e              byte_idx_q;
  logic                   enable_q;
  logic [SIZE_W-1:0]      width_q;
  logic [SIZE_W-1:0]      height_q;
  logic [BYTE_W-1:0]      header_q;
  logic [BYTE_W-1:0]      dx_q;
  logic                   left_held_q;
  logic                   right_held_q;
  logic [COORD_BITS-1:0]  cursor_x_q;
  logic [COORD_BITS-1:0]  cursor_y_q;

  logic                   out_valid_q;
  logic                   changed_q;
  logic [COORD_BITS-1:0]  pos_x_q;
  logic [COORD_BITS-1:0]  pos_y_q;
  logic                   left_q;
  logic                   right_q;
  logic                   dropped_q;

  logic                   accept;
  logic                   work;
  logic                   last_byte;
  logic [COORD_BITS-1:0]  moved_x;
  logic [COORD_BITS-1:0]  moved_y;
  logic                   left_d;
  logic                   right_d;
  logic                   dropped_d;
  logic [COORD_BITS-1:0]  cursor_x_d;
  logic [COORD_BITS-1:0]  cursor_y_d;
  logic                   changed_d;

  assign data_ready_o = !out_valid_q || out_ready_i;
  assign accept       = data_valid_i && data_ready_o;
  assign work         = accept && enable_q;
  assign last_byte    = work && (byte_idx_q == IDX_DY);

  mpct_motion u_motion (
    .cursor_x_i (cursor_x_q),
    .cursor_y_i (cursor_y_q),
    .dx_i       (dx_q),
    .dy_i       (data_byte_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .new_x_o    (moved_x),
    .new_y_o    (moved_y)
  );

  assign left_d     = |(header_q & LEFT_BIT);
  assign right_d    = |(header_q & RIGHT_BIT);
  assign dropped_d  = |(header_q & OVERFLOW_BITS);
  assign cursor_x_d = dropped_d ? cursor_x_q : moved_x;
  assign cursor_y_d = dropped_d ? cursor_y_q : moved_y;
  assign changed_d  = (left_d != left_held_q) || (right_d != right_held_q) ||
                      (cursor_x_d != cursor_x_q) || (cursor_y_d != cursor_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q   <= IDX_HEADER;
      enable_q     <= 1'b0;
      width_q      <= WIDTH_RESET;
      height_q     <= HEIGHT_RESET;
      header_q     <= '0;
      dx_q         <= '0;
      left_held_q  <= 1'b0;
      right_held_q <= 1'b0;
      cursor_x_q   <= X_RESET;
      cursor_y_q   <= Y_RESET;
      out_valid_q  <= 1'b0;
      changed_q    <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      left_q       <= 1'b0;
      right_q      <= 1'b0;
      dropped_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLE:        enable_q <= cfg_data_i[0];
          CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
          CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
          default: ;
        endcase
      end

      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (work) begin
        case (byte_idx_q)
          IDX_HEADER: begin
            if (|(data_byte_i & SYNC_BIT)) begin
              header_q   <= data_byte_i;
              byte_idx_q <= IDX_DX;
            end
          end
          IDX_DX: begin
            dx_q       <= data_byte_i;
            byte_idx_q <= IDX_DY;
          end
          IDX_DY: begin
            byte_idx_q   <= IDX_HEADER;
            left_held_q  <= left_d;
            right_held_q <= right_d;
            cursor_x_q   <= cursor_x_d;
            cursor_y_q   <= cursor_y_d;
            out_valid_q  <= 1'b1;
            changed_q    <= changed_d;
            pos_x_q      <= cursor_x_d;
            pos_y_q      <= cursor_y_d;
            left_q       <= left_d;
            right_q      <= right_d;
            dropped_q    <= dropped_d;
          end
          default: byte_idx_q <= IDX_HEADER;
        endcase
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign changed_o        = changed_q;
  assign pos_x_o          = pos_x_q;
  assign pos_y_o          = pos_y_q;
  assign left_button_o    = left_q;
  assign right_button_o   = right_q;
  assign motion_dropped_o = dropped_q;

  // a completed packet always lands in the result register
  a_packet_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte |=> out_valid_q)
    else $error("completed packet produced no result");

  // words taken while disabled leave the byte count alone
  a_disabled_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !enable_q) |=> $stable(byte_idx_q))
    else $error("byte count moved while disabled");

  // overflow keeps the cursor where it was
  a_dropped_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_byte && dropped_d) |=>
      (pos_x_q == $past(cursor_x_q)) && (pos_y_q == $past(cursor_y_q)))
    else $error("dropped motion moved the cursor");

  // result matches the tracked state right after a packet
  a_result_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte |=> (pos_x_q == cursor_x_q) && (pos_y_q == cursor_y_q) &&
                  (left_q == left_held_q) && (right_q == right_held_q))
    else $error("result disagrees with tracked state");

endmodule

`default_nettype wire

// File: verif/tb_mouse_packet_cursor_tracker.sv
import mpct_pkg::*;

typedef logic [BYTE_W-1:0]     mouse_byte_t;
typedef logic [COORD_BITS-1:0] coord_t;
typedef logic [SIZE_W-1:0]     size_t;

typedef struct packed {
  logic   changed;
  coord_t pos_x;
  coord_t pos_y;
  logic   left;
  logic   right;
  logic   dropped;
} cursor_report_t;

class cursor_report_board;
  logic           enabled;
  size_t          width;
  size_t          height;
  logic [1:0]     byte_index;
  mouse_byte_t    header;
  mouse_byte_t    dx;
  logic           left_held;
  logic           right_held;
  coord_t         cur_x;
  coord_t         cur_y;
  cursor_report_t expected_reports[$];
  int unsigned    mismatches;

  function new();
    enabled    = 1'b0;
    width      = WIDTH_RESET;
    height     = HEIGHT_RESET;
    byte_index = '0;
    header     = '0;
    dx         = '0;
    left_held  = 1'b0;
    right_held = 1'b0;
    cur_x      = X_RESET;
    cur_y      = Y_RESET;
    mismatches = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ENABLE:        enabled = val[0];
      CFG_SCREEN_WIDTH:  width   = val[SIZE_W-1:0];
      CFG_SCREEN_HEIGHT: height  = val[SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  function coord_t clamp_axis(int v, size_t size);
    int lim;
    int lim_max = (1 << COORD_BITS) - 1;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > lim_max) lim = lim_max;
    if (v < 0) return '0;
    if (v > lim) return coord_t'(lim);
    return coord_t'(v);
  endfunction

  function void note_byte(mouse_byte_t b);
    cursor_report_t r;
    logic           l_now;
    logic           r_now;
    coord_t         cx;
    coord_t         cy;
    if (!enabled) return;
    case (byte_index)
      2'd0: begin
        if ((b & SYNC_BIT) != 0) begin
          header     = b;
          byte_index = 2'd1;
        end
      end
      2'd1: begin
        dx         = b;
        byte_index = 2'd2;
      end
      default: begin
        byte_index = 2'd0;
        l_now      = (header & LEFT_BIT) != 0;
        r_now      = (header & RIGHT_BIT) != 0;
        r.changed  = (l_now != left_held) || (r_now != right_held);
        left_held  = l_now;
        right_held = r_now;
        r.dropped  = (header & OVERFLOW_BITS) != 0;
        if (!r.dropped) begin
          cx = clamp_axis(int'(cur_x) + int'($signed(dx)), width);
          cy = clamp_axis(int'(cur_y) - int'($signed(b)), height);
          if (cx != cur_x || cy != cur_y) r.changed = 1'b1;
          cur_x = cx;
          cur_y = cy;
        end
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        r.left  = left_held;
        r.right = right_held;
        expected_reports.push_back(r);
      end
    endcase
  endfunction

  function void check_report(logic chg, coord_t x, coord_t y, logic l, logic rb, logic d);
    cursor_report_t e;
    if (expected_reports.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: chg=%0d x=%0d y=%0d l=%0d r=%0d drop=%0d",
                 chg, x, y, l, rb, d);
      mismatches++;
      return;
    end
    e = expected_reports.pop_front();
    if (e.changed !== chg || e.pos_x !== x || e.pos_y !== y || e.left !== l ||
        e.right !== rb || e.dropped !== d) begin
      if (mismatches < 10) begin
        $write("mismatch: exp chg=%0d x=%0d y=%0d l=%0d r=%0d drop=%0d, ",
               e.changed, e.pos_x, e.pos_y, e.left, e.right, e.dropped);
        $display("got chg=%0d x=%0d y=%0d l=%0d r=%0d drop=%0d",
                 chg, x, y, l, rb, d);
      end
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction
endclass

module tb_mouse_packet_cursor_tracker;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  data_valid_i;
  logic                  data_ready_o;
  mouse_byte_t           data_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  changed_o;
  coord_t                pos_x_o;
  coord_t                pos_y_o;
  logic                  left_button_o;
  logic                  right_button_o;
  logic                  motion_dropped_o;

  cursor_report_board sb;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 long_hold_req;
  int                 stall_cycles = 0;

  mouse_packet_cursor_tracker u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .data_valid_i     (data_valid_i),
    .data_ready_o     (data_ready_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .changed_o        (changed_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .left_button_o    (left_button_o),
    .right_button_o   (right_button_o),
    .motion_dropped_o (motion_dropped_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (data_valid_i && data_ready_o) sb.note_byte(data_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_report(changed_o, pos_x_o, pos_y_o, left_button_o, right_button_o,
                        motion_dropped_o);
    end
  end

  always @(posedge clk_i) begin
    if ((data_valid_i && data_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver side, with an optional long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(mouse_byte_t b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      data_valid_i <= 1'b0;
      data_byte_i  <= mouse_byte_t'($urandom);
      @(negedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_byte_i  <= b;
    do @(posedge clk_i); while (!data_ready_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    sb.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // let every pending packet drain before touching the registers
  task automatic quiesce();
    @(negedge clk_i);
    data_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_packet(int bias);
    mouse_byte_t hdr;
    mouse_byte_t dx;
    mouse_byte_t dy;
    mouse_byte_t extremes[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(mouse_byte_t'($urandom));
      return;
    end
    hdr = mouse_byte_t'($urandom) | SYNC_BIT;
    if ($urandom_range(0, 99) >= 15) hdr = hdr & ~OVERFLOW_BITS;
    if (bias > 0) begin
      dx = mouse_byte_t'($urandom_range(8'h70, 8'h7F));
      dy = mouse_byte_t'($urandom_range(8'h80, 8'h90));
    end else if (bias < 0) begin
      dx = mouse_byte_t'($urandom_range(8'h80, 8'hB0));
      dy = mouse_byte_t'($urandom_range(8'h50, 8'h7F));
    end else if ($urandom_range(0, 3) == 0) begin
      dx = extremes[$urandom_range(0, 3)];
      dy = extremes[$urandom_range(0, 3)];
    end else begin
      dx = mouse_byte_t'($urandom);
      dy = mouse_byte_t'($urandom);
    end
    send_byte(hdr);
    // broken packet: header only, the next header lands as motion
    if (roll < 12) return;
    send_byte(dx);
    send_byte(dy);
  endtask

  task automatic directed_part();
    mouse_byte_t off_bytes[3] = '{8'h08, 8'h01, 8'h01};
    mouse_byte_t on_bytes[20] = '{8'h00, 8'hF7,
                                  8'h08, 8'h7F, 8'h80,
                                  8'h0B, 8'h80, 8'h7F,
                                  8'h4A, 8'h7F, 8'h7F,
                                  8'h89, 8'h01, 8'hFF,
                                  8'hC8, 8'h00, 8'h00,
                                  8'h08, 8'h00, 8'h00};
    foreach (off_bytes[i]) send_byte(off_bytes[i]);
    quiesce();
    write_reg(CFG_ENABLE, 1);
    foreach (on_bytes[i]) send_byte(on_bytes[i]);
    // disable in the middle of a packet
    send_byte(8'h0C);
    quiesce();
    write_reg(CFG_ENABLE, 0);
    send_byte(8'h55);
    quiesce();
    write_reg(CFG_ENABLE, 1);
    send_byte(8'h10);
    send_byte(8'hF0);
  endtask

  initial begin
    int          w;
    int          h;
    int          bias;
    int          count;
    sb            = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_ENABLE;
    cfg_data_i    = '0;
    data_valid_i  = 1'b0;
    data_byte_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_part();

    for (int ph = 0; ph < 9; ph++) begin
      quiesce();
      send_idle_pct = (ph < 3) ? 23 : (ph < 6) ? 82 : 0;
      recv_idle_pct = (ph < 3) ? 82 : (ph < 6) ? 23 : 0;
      bias  = 0;
      count = 22;
      case (ph)
        0: begin w = 4096; h = 4096; bias = 1; end
        1: begin w = 1;    h = 1;    end
        2: begin w = 0;    h = 0;    end
        3: begin w = 8191; h = 8191; bias = 1; count = 40; end
        4: begin w = 100;  h = 50;   end
        5: begin w = 1;    h = 4096; end
        6: begin w = 640;  h = 480;  end
        7: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
        default: begin
          w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); bias = -1;
        end
      endcase
      write_reg(CFG_SCREEN_WIDTH, w);
      write_reg(CFG_SCREEN_HEIGHT, h);
      // cursor now lies beyond the shrunken screen; overflow keeps it there
      if (ph == 4) begin
        send_byte(8'hC8);
        send_byte(8'h00);
        send_byte(8'h00);
      end
      if (ph == 6) begin
        write_reg(CFG_ENABLE, 0);
        repeat (15) send_byte(mouse_byte_t'($urandom));
        quiesce();
        write_reg(CFG_ENABLE, 1);
      end
      if (ph == 8) long_hold_req = 1'b1;
      repeat (count) send_packet(bias);
    end

    quiesce();
    repeat (6) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
